>>> hdl/assert_macros.svh
// Concurrent assertion helpers; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fsp_pkg.sv
package fsp_pkg;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_SKIP,
        PH_TAG,
        PH_REST,
        PH_SEQ,
        PH_HALT,
        PH_NEXT
    } phase_t;

    localparam logic [2:0] KIND_DROP    = 3'd0;
    localparam logic [2:0] KIND_RESIDUE = 3'd1;
    localparam logic [2:0] KIND_TAG     = 3'd2;
    localparam logic [2:0] KIND_HEADER  = 3'd3;
    localparam logic [2:0] KIND_START   = 3'd4;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_START = 2'd1;
    localparam logic [1:0] ERR_MID_LINE = 2'd2;

    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [2:0] ADDR_SEQ_TYPE = 3'd0;

    typedef struct packed {
        phase_t      phase;
        logic        after_line_break;
        logic [15:0] record_counter;
        logic [1:0]  error_flag;
    } ctl_state_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] ch;
        logic       done;
    } step_result_t;

    // upper-cased residue, or zero when not in the selected alphabet
    function automatic logic [7:0] residue_of(input logic [7:0] c, input logic amino);
        logic [7:0] u;
        logic       hit;
        u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        if (amino)
            hit = u inside {"A", "B", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M", "N",
                            "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Z", "-", "*"};
        else
            hit = u inside {"G", "A", "T", "C", "N", "B", "D", "H", "K", "M", "R", "S",
                            "V", "W", "Y", "-"};
        return hit ? u : 8'h00;
    endfunction

endpackage

>>> hdl/fsp_step.sv
module fsp_step
    import fsp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  ctl_state_t             st,
    input  logic [LENGTH_BITS-1:0] count,
    input  logic                   seq_type,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    output ctl_state_t             st_next,
    output logic [LENGTH_BITS-1:0] count_next,
    output step_result_t           res,
    output logic [31:0]            done_length
);

    logic [LENGTH_BITS-1:0] dlen;
    logic [63:0]            dlen_wide;
    logic                   open_rec;
    logic                   drop;
    logic                   is_eol;
    logic                   is_blank;
    logic [7:0]             resid;

    assign is_eol   = (text_byte == CH_CR) || (text_byte == CH_LF);
    assign is_blank = (text_byte == CH_SP) || (text_byte == CH_TAB);
    assign drop     = (st.phase == PH_HALT) || (text_byte == 8'h00) || text_byte[7];
    assign resid    = residue_of(text_byte, seq_type);

    always_comb
    begin
        st_next    = st;
        count_next = count;
        res.kind   = KIND_DROP;
        res.ch     = 8'h00;
        res.done   = 1'b0;
        dlen       = '0;
        open_rec   = (st.phase == PH_SKIP) || (st.phase == PH_TAG) ||
                     (st.phase == PH_REST) || (st.phase == PH_SEQ);

        if (drop)
        begin
        end
        else if ((st.phase == PH_FIRST) || (st.phase == PH_NEXT) ||
                 ((st.phase == PH_SEQ) && (text_byte == CH_GT)))
        begin
            if (text_byte != CH_GT)
            begin
                st_next.error_flag = ERR_NO_START;
                st_next.phase      = PH_HALT;
                open_rec           = 1'b0;
            end
            else if ((st.phase == PH_SEQ) && !st.after_line_break)
            begin
                st_next.error_flag = ERR_MID_LINE;
                st_next.phase      = PH_HALT;
                open_rec           = 1'b0;
            end
            else
            begin
                if (st.phase == PH_SEQ)
                begin
                    res.done = 1'b1;
                    dlen     = count;
                end
                if ((st.phase != PH_FIRST) && (st.record_counter != 16'hFFFF))
                    st_next.record_counter = st.record_counter + 16'd1;
                res.kind                 = KIND_START;
                res.ch                   = text_byte;
                count_next               = '0;
                st_next.after_line_break = 1'b0;
                st_next.phase            = PH_SKIP;
                open_rec                 = !res.done;
            end
        end
        else if (st.phase == PH_SEQ)
        begin
            st_next.after_line_break = is_eol;
            if (resid != 8'h00)
            begin
                res.kind = KIND_RESIDUE;
                res.ch   = resid;
                if (count != '1)
                    count_next = count + LENGTH_BITS'(1);
            end
        end
        else if (is_eol)
        begin
            st_next.phase            = PH_SEQ;
            st_next.after_line_break = 1'b1;
        end
        else if (st.phase == PH_SKIP)
        begin
            res.ch = text_byte;
            if ((text_byte == CH_GT) || is_blank)
                res.kind = KIND_HEADER;
            else
            begin
                res.kind      = KIND_TAG;
                st_next.phase = PH_TAG;
            end
        end
        else if (st.phase == PH_TAG)
        begin
            res.ch = text_byte;
            if (is_blank)
            begin
                res.kind      = KIND_HEADER;
                st_next.phase = PH_REST;
            end
            else
                res.kind = KIND_TAG;
        end
        else
        begin
            res.kind = KIND_HEADER;
            res.ch   = text_byte;
        end

        if (end_of_text && (st_next.phase != PH_HALT))
        begin
            if (!res.done && open_rec)
            begin
                res.done = 1'b1;
                dlen     = count_next;
            end
            if ((st_next.phase != PH_FIRST) || (res.kind == KIND_START))
                st_next.phase = PH_NEXT;
            count_next               = '0;
            st_next.after_line_break = 1'b0;
        end
    end

    assign dlen_wide   = 64'(dlen);
    assign done_length = (|dlen_wide[63:32]) ? 32'hFFFF_FFFF : dlen_wide[31:0];

endmodule

>>> hdl/fasta_stream_parser.sv
// FASTA stream parser: takes one text byte per transfer and returns one result per byte
// from the result register, at a sustained rate of one byte per cycle while out_ready does
// not stall the output. The rate is set by the per-byte parser state (phase, line-start
// flag, residue count, record index, error), which a single combinational step between the
// input register and the result register updates as each byte moves on. seq_type
// (address 0) selects the nucleotide or amino-acid alphabet; write it only while no byte is in flight.
`include "assert_macros.svh"

module fasta_stream_parser
    import fsp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_kind,
    output logic [7:0]  out_char,
    output logic        record_done,
    output logic [31:0] done_length,
    output logic [15:0] record_number,
    output logic [1:0]  error_code
);

    logic                   seq_type_reg;
    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_eot_reg;
    ctl_state_t             st_reg;
    ctl_state_t             st_next;
    logic [LENGTH_BITS-1:0] count_reg;
    logic [LENGTH_BITS-1:0] count_next;
    step_result_t           res;
    logic [31:0]            dlen;
    logic                   advance;

    logic                   out_valid_reg;
    logic [2:0]             kind_reg;
    logic [7:0]             char_reg;
    logic                   done_reg;
    logic [31:0]            dlen_reg;
    logic [15:0]            rec_reg;
    logic [1:0]             err_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_SEQ_TYPE[2]) ? {31'd0, seq_type_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seq_type_reg <= 1'b0;
        else if (psel && penable && pwrite && (paddr[2] == ADDR_SEQ_TYPE[2]))
            seq_type_reg <= pwdata[0];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= text_byte;
            in_eot_reg  <= end_of_text;
        end
    end

    fsp_step #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_step (
        .st          (st_reg),
        .count       (count_reg),
        .seq_type    (seq_type_reg),
        .text_byte   (in_byte_reg),
        .end_of_text (in_eot_reg),
        .st_next     (st_next),
        .count_next  (count_next),
        .res         (res),
        .done_length (dlen)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase            <= PH_FIRST;
            st_reg.after_line_break <= 1'b0;
            st_reg.record_counter   <= 16'd0;
            st_reg.error_flag       <= ERR_NONE;
            count_reg               <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg    <= st_next;
                count_reg <= count_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg <= res.kind;
            char_reg <= res.ch;
            done_reg <= res.done;
            dlen_reg <= dlen;
            rec_reg  <= st_next.record_counter;
            err_reg  <= st_next.error_flag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign byte_kind     = kind_reg;
    assign out_char      = char_reg;
    assign record_done   = done_reg;
    assign done_length   = dlen_reg;
    assign record_number = rec_reg;
    assign error_code    = err_reg;

    `ASSERT_NEXT(a_err_sticky, st_reg.error_flag != ERR_NONE, st_reg.error_flag == $past(st_reg.error_flag), "error flag changed after being set")
    `ASSERT_IMPL(a_halt_err, 1'b1, (st_reg.phase == PH_HALT) == (st_reg.error_flag != ERR_NONE), "halt phase and error flag disagree")
    `ASSERT_IMPL(a_drop_char, out_valid_reg && (kind_reg == KIND_DROP), char_reg == 8'h00, "dropped byte carries a character")
    `ASSERT_IMPL(a_len_idle, out_valid_reg && !done_reg, dlen_reg == 32'd0, "length shown without record end")
    `ASSERT_NEXT(a_hold_in, in_valid_reg && out_valid_reg && !out_ready, in_valid_reg && $stable(in_byte_reg), "input register lost a stalled byte")

endmodule

>>> tb/fasta_result_checker.sv
module fasta_result_checker
    import fsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  text_byte,
    input  logic        end_of_text,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  byte_kind,
    input  logic [7:0]  out_char,
    input  logic        record_done,
    input  logic [31:0] done_length,
    input  logic [15:0] record_number,
    input  logic [1:0]  error_code,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic        done;
        logic [31:0] length;
        logic [15:0] rec_num;
        logic [1:0]  err;
    } parse_outcome_t;

    phase_t         ph;
    logic           at_line_start;
    logic [31:0]    residues;
    logic [15:0]    rec_index;
    logic [1:0]     err_state;
    logic           amino;
    int             mismatches;
    int             results_seen;
    parse_outcome_t outcome_q[$];

    assign fail_count = mismatches;

    function automatic logic [7:0] fold_residue(input logic [7:0] c, input logic aa);
        logic [7:0] u;
        logic       hit;
        u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
        hit = 1'b0;
        if (aa)
        begin
            case (u)
                "A", "B", "C", "D", "E", "F", "G", "H", "I", "K", "L", "M", "N",
                "P", "Q", "R", "S", "T", "U", "V", "W", "X", "Z", "-", "*":
                    hit = 1'b1;
                default:
                    hit = 1'b0;
            endcase
        end
        else
        begin
            case (u)
                "G", "A", "T", "C", "N", "B", "D", "H", "K", "M", "R", "S",
                "V", "W", "Y", "-":
                    hit = 1'b1;
                default:
                    hit = 1'b0;
            endcase
        end
        return hit ? u : 8'h00;
    endfunction

    function automatic parse_outcome_t parse_next_byte(input logic [7:0] c, input logic eot);
        parse_outcome_t r;
        logic [7:0]     res;
        logic           open_rec;
        r = '0;
        open_rec = (ph == PH_SKIP || ph == PH_TAG || ph == PH_REST || ph == PH_SEQ);
        if (ph == PH_HALT || c == 8'h00 || c[7])
        begin
            // drop
        end
        else if (ph == PH_FIRST || ph == PH_NEXT || (ph == PH_SEQ && c == CH_GT))
        begin
            if (c != CH_GT)
            begin
                err_state = ERR_NO_START;
                ph = PH_HALT;
                open_rec = 1'b0;
            end
            else if (ph == PH_SEQ && !at_line_start)
            begin
                err_state = ERR_MID_LINE;
                ph = PH_HALT;
                open_rec = 1'b0;
            end
            else
            begin
                if (ph == PH_SEQ)
                begin
                    r.done = 1'b1;
                    r.length = residues;
                end
                if (ph != PH_FIRST && rec_index != 16'hFFFF)
                    rec_index++;
                r.kind = KIND_START;
                r.ch = c;
                residues = '0;
                at_line_start = 1'b0;
                ph = PH_SKIP;
                open_rec = !r.done;
            end
        end
        else if (ph == PH_SEQ)
        begin
            res = fold_residue(c, amino);
            at_line_start = (c == CH_CR || c == CH_LF);
            if (res != 8'h00)
            begin
                r.kind = KIND_RESIDUE;
                r.ch = res;
                if (residues != '1)
                    residues++;
            end
        end
        else if (c == CH_CR || c == CH_LF)
        begin
            ph = PH_SEQ;
            at_line_start = 1'b1;
        end
        else if (ph == PH_SKIP)
        begin
            r.ch = c;
            if (c == CH_GT || c == CH_SP || c == CH_TAB)
                r.kind = KIND_HEADER;
            else
            begin
                r.kind = KIND_TAG;
                ph = PH_TAG;
            end
        end
        else if (ph == PH_TAG)
        begin
            r.ch = c;
            if (c == CH_SP || c == CH_TAB)
            begin
                r.kind = KIND_HEADER;
                ph = PH_REST;
            end
            else
                r.kind = KIND_TAG;
        end
        else
        begin
            r.kind = KIND_HEADER;
            r.ch = c;
        end

        if (eot && ph != PH_HALT)
        begin
            if (!r.done && open_rec)
            begin
                r.done = 1'b1;
                r.length = residues;
            end
            if (ph != PH_FIRST || r.kind == KIND_START)
                ph = PH_NEXT;
            residues = '0;
            at_line_start = 1'b0;
        end
        r.rec_num = rec_index;
        r.err = err_state;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("%0t result %0d: %s", $time, results_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            note_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        parse_outcome_t want;
        if (!rst_n)
        begin
            ph = PH_FIRST;
            at_line_start = 1'b0;
            residues = '0;
            rec_index = '0;
            err_state = ERR_NONE;
            amino = 1'b0;
            mismatches = 0;
            results_seen = 0;
            outcome_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_SEQ_TYPE)
                amino = pwdata[0];
            if (out_valid && out_ready)
            begin
                if (outcome_q.size() == 0)
                    note_mismatch("transfer with no expected result");
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("byte_kind", 32'(byte_kind), 32'(want.kind));
                    check_field("out_char", 32'(out_char), 32'(want.ch));
                    check_field("record_done", 32'(record_done), 32'(want.done));
                    check_field("done_length", done_length, want.length);
                    check_field("record_number", 32'(record_number), 32'(want.rec_num));
                    check_field("error_code", 32'(error_code), 32'(want.err));
                end
                results_seen++;
            end
            if (in_valid && in_ready)
                outcome_q.push_back(parse_next_byte(text_byte, end_of_text));
            pending <= outcome_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
module tb_top
    import fsp_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam string RES_POOL = "ACGTNacgtnBDHKMRSVWYbdhkmrsvwy-EFILPQXZefilpqxz*UuJjOo";

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  byte_kind;
    logic [7:0]  out_char;
    logic        record_done;
    logic [31:0] done_length;
    logic [15:0] record_number;
    logic [1:0]  error_code;

    int          fail_count;
    int          pending;
    int          gap_pct;
    int          stall_pct;
    int          items_sent;
    int          cycle_count;
    logic [7:0]  text_buf[$];

    fasta_stream_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_kind     (byte_kind),
        .out_char      (out_char),
        .record_done   (record_done),
        .done_length   (done_length),
        .record_number (record_number),
        .error_code    (error_code)
    );

    fasta_result_checker result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_text   (end_of_text),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .byte_kind     (byte_kind),
        .out_char      (out_char),
        .record_done   (record_done),
        .done_length   (done_length),
        .record_number (record_number),
        .error_code    (error_code),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[fasta_stream_parser] ERROR");
        $finish;
    end

    initial
    begin
        int hold;
        hold = 0;
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
                hold = $urandom_range(1, 18);
            out_ready <= (hold == 0);
        end
    end

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] noise_byte();
        return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(128, 255));
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 50;
        endcase
    endfunction

    task automatic put(input logic [7:0] b, input logic eot);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_seq_type(input logic v);
        drain();
        repeat (3) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_SEQ_TYPE;
        pwdata <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic add_line_break();
        case ($urandom_range(0, 2))
            0: text_buf.push_back(CH_CR);
            1: text_buf.push_back(CH_LF);
            default:
            begin
                text_buf.push_back(CH_CR);
                text_buf.push_back(CH_LF);
            end
        endcase
    endtask

    task automatic add_record();
        logic [7:0] b;
        text_buf.push_back(CH_GT);
        repeat ($urandom_range(0, 2)) text_buf.push_back(pick(">\t "));
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(0, 9) == 0)
                text_buf.push_back(noise_byte());
            else
                text_buf.push_back(8'($urandom_range(33, 126)));
        end
        if ($urandom_range(0, 1))
        begin
            text_buf.push_back(pick("\t "));
            repeat ($urandom_range(0, 10))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_CR || b == CH_LF)
                    b = CH_SP;
                text_buf.push_back(b);
            end
        end
        add_line_break();
        repeat ($urandom_range(0, 4))
        begin
            repeat ($urandom_range(0, ($urandom_range(0, 9) == 0) ? 80 : 20))
            begin
                if ($urandom_range(0, 4) != 0)
                    b = pick(RES_POOL);
                else
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == CH_GT)
                        b = "x";
                end
                text_buf.push_back(b);
            end
            add_line_break();
            if ($urandom_range(0, 5) == 0)
                text_buf.push_back(noise_byte());
        end
    endtask

    task automatic send_text();
        int keep;
        text_buf.delete();
        if ($urandom_range(0, 7) == 0)
            text_buf.push_back(noise_byte());
        repeat ($urandom_range(1, 4)) add_record();
        if ($urandom_range(0, 3) == 0)
        begin
            keep = $urandom_range(1, text_buf.size());
            while (text_buf.size() > keep) void'(text_buf.pop_back());
        end
        foreach (text_buf[i])
            put(text_buf[i], i == text_buf.size() - 1);
        if ($urandom_range(0, 7) == 0)
            put(noise_byte(), 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int target;
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        in_valid <= 1'b0;
        text_byte <= '0;
        end_of_text <= 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_seq_type(1'b0);
        gap_pct = 20;
        stall_pct = 20;
        put(8'hC0, 1'b1);
        put(CH_GT, 1'b1);
        put(CH_GT, 1'b0);
        put(CH_SP, 1'b0);
        put(CH_GT, 1'b0);
        put("a", 1'b0);
        put("Z", 1'b0);
        put(CH_TAB, 1'b0);
        put("r", 1'b0);
        put(CH_CR, 1'b0);
        put(CH_LF, 1'b0);
        put("g", 1'b0);
        put("a", 1'b0);
        put("-", 1'b0);
        put("u", 1'b0);
        put(8'h00, 1'b0);
        put(CH_LF, 1'b0);
        put(8'hFF, 1'b0);
        put(CH_GT, 1'b0);
        put("q", 1'b0);
        put(CH_LF, 1'b0);
        put("y", 1'b0);
        put("*", 1'b0);
        put(8'h7F, 1'b0);
        put("T", 1'b1);

        for (int p = 0; p < 6; p++)
        begin
            write_seq_type((p < 4) ? ~p[0] : 1'($urandom_range(0, 1)));
            target = items_sent + 100;
            while (items_sent < target)
            begin
                gap_pct = pick_pct();
                stall_pct = pick_pct();
                send_text();
            end
        end

        // tail runs at full rate on both sides
        gap_pct = 0;
        stall_pct = 0;
        send_text();
        if ($urandom_range(0, 1))
        begin
            put(CH_GT, 1'b0);
            put("t", 1'b0);
            put(CH_LF, 1'b0);
            put("a", 1'b0);
            put("c", 1'b0);
            put(CH_GT, 1'b0);
        end
        else
            put("A", 1'b0);
        repeat (16)
        begin
            put(($urandom_range(0, 2) == 0) ? CH_GT : 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
        end

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[fasta_stream_parser] OK");
        else
            $display("[fasta_stream_parser] ERROR");
        $finish;
    end

endmodule
